// ===== hdl/bfi_pkg.sv =====
// Shared types and constants for the instruction executor.
// Used by bfi_front, bfi_back and the top level; no dependencies.
package bfi_pkg;

	localparam int TAPE_CELLS  = 4096;
	localparam int TAPE_AW     = $clog2(TAPE_CELLS);
	localparam int STACK_DEPTH = 64;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int CNT_W       = STACK_AW + 1;
	localparam int POS_W       = 16;
	localparam int SKIP_W      = 16;

	localparam logic [7:0] TOK_RIGHT = 8'h3E; // >
	localparam logic [7:0] TOK_LEFT  = 8'h3C; // <
	localparam logic [7:0] TOK_INC   = 8'h2B; // +
	localparam logic [7:0] TOK_DEC   = 8'h2D; // -
	localparam logic [7:0] TOK_OUT   = 8'h2E; // .
	localparam logic [7:0] TOK_IN    = 8'h2C; // ,
	localparam logic [7:0] TOK_OPEN  = 8'h5B; // [
	localparam logic [7:0] TOK_CLOSE = 8'h5D; // ]

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_STRAY      = 3'd1;
	localparam logic [2:0] ERR_OPEN_SKIP  = 3'd2;
	localparam logic [2:0] ERR_INPUT_END  = 3'd3;
	localparam logic [2:0] ERR_TAPE_END   = 3'd4;
	localparam logic [2:0] ERR_STACK_FULL = 3'd5;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_RIGHT,
		OP_LEFT,
		OP_INC,
		OP_DEC,
		OP_OUT,
		OP_IN,
		OP_OPEN,
		OP_CLOSE,
		OP_END
	} bfi_op_t;

	typedef struct packed {
		bfi_op_t            op;
		logic [POS_W-1:0]   next_position;
		logic [7:0]         in_byte;
		logic               in_available;
	} bfi_item_t;

	// back end to queue
	typedef struct packed {
		logic pop;
		logic clr_done;
	} bfi_back_stat_t;

endpackage

// ===== hdl/bfi_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bfi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== hdl/bfi_front.sv =====
// Front end: accepts input beats, decodes the token into an op and holds
// decoded items in a two-entry queue for the back end. Depends on bfi_pkg.
module bfi_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                token,
	input  logic [bfi_pkg::POS_W-1:0] next_position,
	input  logic [7:0]                in_byte,
	input  logic                      in_available,
	input  logic                      program_end,
	output logic                      q_valid,
	output bfi_pkg::bfi_item_t        q_item,
	input  bfi_pkg::bfi_back_stat_t   stat
);
	import bfi_pkg::*;

	bfi_op_t   op;
	bfi_item_t dec_item;
	bfi_item_t ent_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] cnt_q;
	logic      push;
	logic      pop;

	always_comb begin
		if (program_end) begin
			op = OP_END;
		end else begin
			case (token)
				TOK_RIGHT: op = OP_RIGHT;
				TOK_LEFT:  op = OP_LEFT;
				TOK_INC:   op = OP_INC;
				TOK_DEC:   op = OP_DEC;
				TOK_OUT:   op = OP_OUT;
				TOK_IN:    op = OP_IN;
				TOK_OPEN:  op = OP_OPEN;
				TOK_CLOSE: op = OP_CLOSE;
				default:   op = OP_NOP;
			endcase
		end
	end

	assign dec_item = '{op: op, next_position: next_position, in_byte: in_byte,
		in_available: in_available};

	// no beats taken while the tape is still being cleared
	assign in_ready = (cnt_q != 2'd2) && stat.clr_done;
	assign push     = in_valid && in_ready;
	assign pop      = stat.pop;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= dec_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== hdl/bfi_back.sv =====
// Back end: executes decoded items against the tape and loop stack RAMs and
// holds the result in an output register. Depends on bfi_pkg and bfi_ram.
module bfi_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  bfi_pkg::bfi_item_t        q_item,
	output bfi_pkg::bfi_back_stat_t   stat,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic                      out_valid,
	output logic [7:0]                out_byte,
	output logic                      seek_valid,
	output logic [bfi_pkg::POS_W-1:0] seek_position,
	output logic [2:0]                error_code,
	output logic                      halted
);
	import bfi_pkg::*;

	typedef enum logic {S_ISSUE, S_EXEC} state_t;

	state_t               state_q;
	bfi_item_t            item_q;
	logic [TAPE_AW-1:0]   dp_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SKIP_W-1:0]    skip_q;
	logic                 halt_q;
	logic [2:0]           err_q;
	logic                 clr_busy_q;
	logic [TAPE_AW-1:0]   clr_addr_q;
	logic                 res_valid_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 seek_valid_q;
	logic [POS_W-1:0]     seek_pos_q;
	logic [2:0]           err_out_q;
	logic                 halt_out_q;

	logic                 pop;
	logic                 exec_go;
	logic [7:0]           cell_rd;
	logic [POS_W-1:0]     top;

	logic [TAPE_AW-1:0]   nxt_dp;
	logic [CNT_W-1:0]     nxt_cnt;
	logic [SKIP_W-1:0]    nxt_skip;
	logic                 nxt_halt;
	logic [2:0]           nxt_err;
	logic                 o_valid;
	logic [7:0]           o_byte;
	logic                 s_valid;
	logic [POS_W-1:0]     s_pos;
	logic                 tape_wr;
	logic [7:0]           tape_wdata;
	logic                 stk_wr;

	logic                 tape_we;
	logic [TAPE_AW-1:0]   tape_waddr;
	logic [7:0]           tape_wd;

	assign pop          = (state_q == S_ISSUE) && q_valid && !clr_busy_q;
	assign exec_go      = (state_q == S_EXEC) && (!res_valid_q || res_ready);
	assign stat.pop      = pop;
	assign stat.clr_done = !clr_busy_q;

	assign tape_we    = clr_busy_q || (exec_go && tape_wr);
	assign tape_waddr = clr_busy_q ? clr_addr_q : dp_q;
	assign tape_wd    = clr_busy_q ? 8'd0 : tape_wdata;

	bfi_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wd),
		.re    (pop),
		.raddr (dp_q),
		.rdata (cell_rd)
	);

	// top of stack is read speculatively; only used when the stack is nonempty
	bfi_ram #(.WIDTH(POS_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (exec_go && stk_wr),
		.waddr (cnt_q[STACK_AW-1:0]),
		.wdata (item_q.next_position),
		.re    (pop),
		.raddr (cnt_q[STACK_AW-1:0] - STACK_AW'(1)),
		.rdata (top)
	);

	always_comb begin
		nxt_dp     = dp_q;
		nxt_cnt    = cnt_q;
		nxt_skip   = skip_q;
		nxt_halt   = halt_q;
		nxt_err    = err_q;
		o_valid    = 1'b0;
		o_byte     = 8'd0;
		s_valid    = 1'b0;
		s_pos      = '0;
		tape_wr    = 1'b0;
		tape_wdata = cell_rd;
		stk_wr     = 1'b0;
		if (!halt_q) begin
			if (item_q.op == OP_END) begin
				nxt_halt = 1'b1;
				if (skip_q != '0) begin
					nxt_err = ERR_OPEN_SKIP;
				end
			end else if (skip_q != '0) begin
				if (item_q.op == OP_OPEN) begin
					if (skip_q != '1) begin
						nxt_skip = skip_q + SKIP_W'(1);
					end
				end else if (item_q.op == OP_CLOSE) begin
					nxt_skip = skip_q - SKIP_W'(1);
				end
			end else begin
				case (item_q.op)
					OP_RIGHT: begin
						if (dp_q == TAPE_AW'(TAPE_CELLS - 1)) begin
							nxt_err  = ERR_TAPE_END;
							nxt_halt = 1'b1;
						end else begin
							nxt_dp = dp_q + TAPE_AW'(1);
						end
					end
					OP_LEFT: begin
						if (dp_q == '0) begin
							nxt_err  = ERR_TAPE_END;
							nxt_halt = 1'b1;
						end else begin
							nxt_dp = dp_q - TAPE_AW'(1);
						end
					end
					OP_INC: begin
						tape_wr    = 1'b1;
						tape_wdata = cell_rd + 8'd1;
					end
					OP_DEC: begin
						tape_wr    = 1'b1;
						tape_wdata = cell_rd - 8'd1;
					end
					OP_OUT: begin
						o_valid = 1'b1;
						o_byte  = cell_rd;
					end
					OP_IN: begin
						if (!item_q.in_available) begin
							nxt_err  = ERR_INPUT_END;
							nxt_halt = 1'b1;
						end else begin
							tape_wr    = 1'b1;
							tape_wdata = item_q.in_byte;
						end
					end
					OP_OPEN: begin
						if (cell_rd == 8'd0) begin
							nxt_skip = SKIP_W'(1);
						end else if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
							nxt_err  = ERR_STACK_FULL;
							nxt_halt = 1'b1;
						end else begin
							stk_wr  = 1'b1;
							nxt_cnt = cnt_q + CNT_W'(1);
						end
					end
					OP_CLOSE: begin
						if (cnt_q == '0) begin
							nxt_err  = ERR_STRAY;
							nxt_halt = 1'b1;
						end else if (cell_rd != 8'd0) begin
							s_valid = 1'b1;
							s_pos   = top;
						end else begin
							nxt_cnt = cnt_q - CNT_W'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_item;
		end
		if (exec_go) begin
			out_valid_q  <= o_valid;
			out_byte_q   <= o_byte;
			seek_valid_q <= s_valid;
			seek_pos_q   <= s_pos;
			err_out_q    <= nxt_err;
			halt_out_q   <= nxt_halt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ISSUE;
			dp_q        <= TAPE_AW'(TAPE_CELLS / 2);
			cnt_q       <= '0;
			skip_q      <= '0;
			halt_q      <= 1'b0;
			err_q       <= ERR_NONE;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + TAPE_AW'(1);
				if (clr_addr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_ISSUE: begin
					if (pop) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q     <= S_ISSUE;
						dp_q        <= nxt_dp;
						cnt_q       <= nxt_cnt;
						skip_q      <= nxt_skip;
						halt_q      <= nxt_halt;
						err_q       <= nxt_err;
						res_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_ISSUE;
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign seek_valid    = seek_valid_q;
	assign seek_position = seek_pos_q;
	assign error_code    = err_out_q;
	assign halted        = halt_out_q;
endmodule

// ===== hdl/brainfuck_instruction_executor.sv =====
// Top level of the instruction executor: front-end decode queue feeding the
// execution back end. Depends on bfi_pkg, bfi_front, bfi_back and bfi_ram.
//
// Takes one program character per input beat and returns exactly one result
// beat for it. After reset the 4096-cell tape is swept to zero, one cell per
// cycle, and in_ready stays low until the sweep is done. The back end reads
// the tape RAM for an item in S_ISSUE and writes it back in S_EXEC, and it
// takes no new item until the last one is done. A two-entry queue decouples
// the input side, and a result register lets the next item be read while a
// result waits on res_ready. Once halted, items are still taken and each
// returns the held error with halted set.
module brainfuck_instruction_executor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                token,
	input  logic [bfi_pkg::POS_W-1:0] next_position,
	input  logic [7:0]                in_byte,
	input  logic                      in_available,
	input  logic                      program_end,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic                      out_valid,
	output logic [7:0]                out_byte,
	output logic                      seek_valid,
	output logic [bfi_pkg::POS_W-1:0] seek_position,
	output logic [2:0]                error_code,
	output logic                      halted
);
	import bfi_pkg::*;

	logic           q_valid;
	bfi_item_t      q_item;
	bfi_back_stat_t stat;

	bfi_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.token         (token),
		.next_position (next_position),
		.in_byte       (in_byte),
		.in_available  (in_available),
		.program_end   (program_end),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.stat          (stat)
	);

	bfi_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.stat          (stat),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.out_valid     (out_valid),
		.out_byte      (out_byte),
		.seek_valid    (seek_valid),
		.seek_position (seek_position),
		.error_code    (error_code),
		.halted        (halted)
	);
endmodule
